// ===== src/slfpd_pkg.sv =====
// Shared constants, widths and a helper function for the serial line framer.
package slfpd_pkg;

   localparam int LINE_LEN_DEF = 64;

   localparam int RX_W       = 8;
   localparam int CHAR_W     = 7;
   localparam int CHAR_POS_W = 6;
   localparam int MATCH_W    = 4;

   localparam int PROMPT_LEN = 10;
   localparam int GT_END_POS = 9;

   localparam logic [RX_W-1:0]   CH_CR    = 8'h0D;
   localparam logic [RX_W-1:0]   CH_LF    = 8'h0A;
   localparam logic [RX_W-1:0]   CH_HIGH  = 8'h7F;
   localparam logic [CHAR_W-1:0] CH_SUBST = 7'h3F;
   localparam logic [CHAR_W-1:0] CH_GT    = 7'h3E;
   localparam logic [CHAR_W-1:0] CH_NUL   = 7'h00;
   localparam logic [CHAR_W-1:0] CH_LF7   = 7'h0A;

   // Prompt text, one character per match index.
   function automatic logic [CHAR_W-1:0] prompt_char(input logic [MATCH_W-1:0] idx);
      logic [CHAR_W-1:0] ch;
      case (idx)
         4'd0:    ch = 7'h6C;
         4'd1:    ch = 7'h65;
         4'd2:    ch = 7'h61;
         4'd3:    ch = 7'h70;
         4'd4:    ch = 7'h4D;
         4'd5:    ch = 7'h4D;
         4'd6:    ch = 7'h57;
         4'd7:    ch = 7'h3A;
         4'd8:    ch = 7'h2F;
         4'd9:    ch = 7'h3E;
         default: ch = 7'h00;
      endcase
      return ch;
   endfunction

endpackage

// ===== src/slfpd_if.sv =====
// Valid/ready channel interfaces for the framer's request and response beats.
interface slfpd_req_if import slfpd_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [RX_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface slfpd_rsp_if import slfpd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  char_kept;
   logic [CHAR_W-1:0]     char_out;
   logic [CHAR_POS_W-1:0] char_pos;
   logic                  line_done;
   logic                  prompt_found;

   modport source (output valid, output char_kept, output char_out, output char_pos,
                   output line_done, output prompt_found, input ready);
   modport sink   (input valid, input char_kept, input char_out, input char_pos,
                   input line_done, input prompt_found, output ready);
endinterface

// ===== src/serial_line_framer_prompt_detect.sv =====
// Top level: serial line framer with streaming prompt detection.
// An accepted req beat is presented as its rsp beat from the result register in the next cycle.
// Throughput: one byte per clock; req.ready stays high while the result register
//   is empty or being drained in the same cycle, so beats stream back to back.
// Reset (synchronous, active high): line position, matcher state and the
//   response valid flag clear to zero; payload registers are not reset.
module serial_line_framer_prompt_detect
   import slfpd_pkg::*;
#(
   parameter int LINE_LEN = LINE_LEN_DEF
) (
   input  logic         clock,
   input  logic         reset,
   slfpd_req_if.sink    req,
   slfpd_rsp_if.source  rsp
);

   localparam int POS_W = $clog2(LINE_LEN + 1);

   // ---------------- line and matcher state ----------------
   logic [POS_W-1:0]   write_pos_ff,      write_pos_in;
   logic [MATCH_W-1:0] match_progress_ff, match_progress_in;
   logic               prompt_seen_ff,    prompt_seen_in;
   logic               zero_seen_ff,      zero_seen_in;

   // ---------------- result register ----------------
   logic                  rsp_valid_ff,    rsp_valid_in;
   logic                  char_kept_ff,    char_kept_in;
   logic [CHAR_W-1:0]     char_out_ff,     char_out_in;
   logic [CHAR_POS_W-1:0] char_pos_ff,     char_pos_in;
   logic                  line_done_ff,    line_done_in;
   logic                  prompt_found_ff, prompt_found_in;

   logic                  req_fire;

   // Working values after the full-line wrap
   logic                  wrap;
   logic [POS_W-1:0]      pos_base;
   logic [MATCH_W-1:0]    mp_base;
   logic                  seen_base;
   logic                  zero_base;

   // Per-byte decode and matcher step
   logic                  is_cr;
   logic                  is_lf;
   logic [CHAR_W-1:0]     ch;
   logic [MATCH_W-1:0]    mp_cur;
   logic [MATCH_W-1:0]    mp_step;
   logic                  seen_step;
   logic                  zero_step;
   logic                  done;

   // Take a new beat whenever the result register is free or being emptied.
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign req_fire  = req.valid && req.ready;

   always_comb begin
      // A full line wraps to position 0 before anything else, CR included.
      wrap      = (write_pos_ff == POS_W'(LINE_LEN));
      pos_base  = wrap ? '0   : write_pos_ff;
      mp_base   = wrap ? '0   : match_progress_ff;
      seen_base = wrap ? 1'b0 : prompt_seen_ff;
      zero_base = wrap ? 1'b0 : zero_seen_ff;

      is_cr = (req.rx_byte == CH_CR);
      is_lf = (req.rx_byte == CH_LF);
      ch    = (req.rx_byte >= CH_HIGH) ? CH_SUBST : req.rx_byte[CHAR_W-1:0];

      // Streaming matcher. The first prompt character occurs only once in the
      // prompt, so a mismatch restarts at 0, or at 1 on that character.
      mp_cur    = (mp_base >= MATCH_W'(PROMPT_LEN)) ? '0 : mp_base;
      mp_step   = mp_base;
      seen_step = seen_base;
      zero_step = zero_base;
      if (!zero_base) begin
         if (ch == CH_NUL) begin
            zero_step = 1'b1;
         end else if (ch == prompt_char(mp_cur)) begin
            if (mp_cur == MATCH_W'(PROMPT_LEN - 1)) begin
               seen_step = 1'b1;
               mp_step   = '0;
            end else begin
               mp_step = mp_cur + MATCH_W'(1);
            end
         end else begin
            mp_step = (ch == prompt_char('0)) ? MATCH_W'(1) : '0;
         end
      end

      // LF never enters the matcher; '>' at the end-mark position ends the line
      // after it has been matched.
      if (is_lf) begin
         mp_step   = mp_base;
         seen_step = seen_base;
         zero_step = zero_base;
      end
      done = is_lf || ((pos_base == POS_W'(GT_END_POS)) && (ch == CH_GT));

      // State update
      write_pos_in      = write_pos_ff;
      match_progress_in = match_progress_ff;
      prompt_seen_in    = prompt_seen_ff;
      zero_seen_in      = zero_seen_ff;
      if (req_fire) begin
         if (is_cr) begin
            write_pos_in      = pos_base;
            match_progress_in = mp_base;
            prompt_seen_in    = seen_base;
            zero_seen_in      = zero_base;
         end else if (done) begin
            write_pos_in      = '0;
            match_progress_in = '0;
            prompt_seen_in    = 1'b0;
            zero_seen_in      = 1'b0;
         end else begin
            write_pos_in      = pos_base + POS_W'(1);
            match_progress_in = mp_step;
            prompt_seen_in    = seen_step;
            zero_seen_in      = zero_step;
         end
      end

      // Result register: load on accept, hold otherwise.
      rsp_valid_in    = req_fire || (rsp_valid_ff && !rsp.ready);
      char_kept_in    = char_kept_ff;
      char_out_in     = char_out_ff;
      char_pos_in     = char_pos_ff;
      line_done_in    = line_done_ff;
      prompt_found_in = prompt_found_ff;
      if (req_fire) begin
         if (is_cr) begin
            // Dropped CR reports an all-zero beat.
            char_kept_in    = 1'b0;
            char_out_in     = '0;
            char_pos_in     = '0;
            line_done_in    = 1'b0;
            prompt_found_in = 1'b0;
         end else begin
            char_kept_in    = 1'b1;
            char_out_in     = ch;
            char_pos_in     = CHAR_POS_W'(pos_base);
            line_done_in    = done;
            prompt_found_in = done && seen_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_pos_ff      <= '0;
         match_progress_ff <= '0;
         prompt_seen_ff    <= 1'b0;
         zero_seen_ff      <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         write_pos_ff      <= write_pos_in;
         match_progress_ff <= match_progress_in;
         prompt_seen_ff    <= prompt_seen_in;
         zero_seen_ff      <= zero_seen_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_kept_ff    <= char_kept_in;
      char_out_ff     <= char_out_in;
      char_pos_ff     <= char_pos_in;
      line_done_ff    <= line_done_in;
      prompt_found_ff <= prompt_found_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.char_kept    = char_kept_ff;
   assign rsp.char_out     = char_out_ff;
   assign rsp.char_pos     = char_pos_ff;
   assign rsp.line_done    = line_done_ff;
   assign rsp.prompt_found = prompt_found_ff;

`ifndef NO_ASSERTIONS
   // A prompt hit is only reported on a line-end beat.
   a_found_only_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && prompt_found_ff |-> line_done_ff)
      else $error("prompt_found without line_done");

   // A dropped CR carries no character and never ends a line.
   a_cr_beat_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !char_kept_ff |-> (char_out_ff == '0) && !line_done_ff)
      else $error("dropped CR beat carries data");

   // A line ends either on LF or on '>' stored at the end-mark position.
   a_end_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && line_done_ff |->
         (char_out_ff == CH_LF7) ||
         ((char_out_ff == CH_GT) && (char_pos_ff == CHAR_POS_W'(GT_END_POS))))
      else $error("line end without LF or end mark");

   // The matcher index never runs past the prompt.
   a_match_range: assert property (@(posedge clock) disable iff (reset)
      match_progress_ff < MATCH_W'(PROMPT_LEN))
      else $error("match index out of range");
`endif

endmodule

// ===== tb/serial_line_framer_prompt_detect_test.sv =====
// Self-checking testbench for the serial line framer: directed rows, then random line traffic.
module serial_line_framer_prompt_detect_test;
   import slfpd_pkg::*;

   // Prompt text as bytes, first character in the top byte.
   localparam logic [8*PROMPT_LEN-1:0] PROMPT_BYTES = 80'h6C65_6170_4D4D_573A_2F3E;
   localparam int PHASE_ITEMS = 225;   // at least this many random beats per idling phase
   localparam int QUIET_LIMIT = 2000;  // cycles without any handshake before giving up

   // One response beat, laid out as the rsp channel carries it.
   typedef struct packed {
      logic                  kept;
      logic [CHAR_W-1:0]     ch;
      logic [CHAR_POS_W-1:0] pos;
      logic                  done;
      logic                  found;
   } framer_beat_type;

   // Directed row: byte to send, whether the expected beat is typed in, and that beat.
   typedef struct packed {
      logic [RX_W-1:0] rx;
      logic            typed;
      framer_beat_type want;
   } dir_row_type;

   logic clock;
   logic reset;

   slfpd_req_if req_ch ();
   slfpd_rsp_if rsp_ch ();

   serial_line_framer_prompt_detect uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // Predictor state: next line position and the streaming prompt matcher.
   int line_pos   = 0;
   int prompt_idx = 0;
   bit prompt_hit = 1'b0;
   bit nul_hit    = 1'b0;

   framer_beat_type beats_due[$];      // expected rsp beats, oldest first
   logic [RX_W-1:0] pending_bytes[$];  // bytes planned for the current line
   int bad_beats    = 0;
   int quiet_cycles = 0;
   int idle_pct     = 0;               // chance the sender skips a cycle
   int stall_pct    = 0;               // chance the receiver holds ready low

   // Directed rows. Columns: rx, typed, {kept, ch, pos, done, found}.
   // Typed rows carry values that follow directly from the reset state.
   dir_row_type dir_rows[$] = '{
      {8'h61, 1'b1, 1'b1, 7'h61, 6'd0, 1'b0, 1'b0},   // plain char right after reset
      {8'h0D, 1'b1, 1'b0, 7'h00, 6'd0, 1'b0, 1'b0},   // CR dropped, all fields zero
      {8'h7F, 1'b1, 1'b1, 7'h3F, 6'd1, 1'b0, 1'b0},   // lowest high byte -> '?'
      {8'hFF, 1'b1, 1'b1, 7'h3F, 6'd2, 1'b0, 1'b0},   // top byte -> '?'
      {8'h80, 1'b1, 1'b1, 7'h3F, 6'd3, 1'b0, 1'b0},
      {8'h7E, 1'b1, 1'b1, 7'h7E, 6'd4, 1'b0, 1'b0},   // highest char stored as is
      {8'h00, 1'b1, 1'b1, 7'h00, 6'd5, 1'b0, 1'b0},   // zero byte stored, matching stops
      {8'h6C, 1'b1, 1'b1, 7'h6C, 6'd6, 1'b0, 1'b0},
      {8'h0A, 1'b1, 1'b1, 7'h0A, 6'd7, 1'b1, 1'b0},   // LF ends line, no prompt
      {8'h6C, 1'b0, 16'h0000},                          // prompt from position 0 ...
      {8'h65, 1'b0, 16'h0000},
      {8'h61, 1'b0, 16'h0000},
      {8'h70, 1'b0, 16'h0000},
      {8'h4D, 1'b0, 16'h0000},
      {8'h4D, 1'b0, 16'h0000},
      {8'h57, 1'b0, 16'h0000},
      {8'h3A, 1'b0, 16'h0000},
      {8'h2F, 1'b0, 16'h0000},
      {8'h3E, 1'b1, 1'b1, 7'h3E, 6'd9, 1'b1, 1'b1},   // ... '>' at 9 ends line, found
      {8'h3E, 1'b1, 1'b1, 7'h3E, 6'd0, 1'b0, 1'b0},   // '>' elsewhere is just text
      {8'h0A, 1'b1, 1'b1, 7'h0A, 6'd1, 1'b1, 1'b0},
      {8'h0A, 1'b1, 1'b1, 7'h0A, 6'd0, 1'b1, 1'b0},   // empty line
      {8'h01, 1'b0, 16'h0000},
      {8'h0A, 1'b0, 16'h0000}
   };

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [RX_W-1:0] prompt_byte(input int idx);
      return PROMPT_BYTES[8*(PROMPT_LEN-idx)-1 -: 8];
   endfunction

   // Advances the predictor by one byte and returns the beat it should produce.
   function automatic framer_beat_type frame_byte(input logic [RX_W-1:0] rx);
      framer_beat_type beat;
      logic [RX_W-1:0] c;
      int              p;
      bit              done;
      beat = '0;
      done = 1'b0;
      // full line wraps before anything else, CR included
      if (line_pos >= LINE_LEN_DEF) begin
         line_pos   = 0;
         prompt_idx = 0;
         prompt_hit = 1'b0;
         nul_hit    = 1'b0;
      end
      if (rx == CH_CR)
         return beat;
      c = (rx >= CH_HIGH) ? {1'b0, CH_SUBST} : rx;
      beat.kept = 1'b1;
      beat.ch   = c[CHAR_W-1:0];
      beat.pos  = line_pos[CHAR_POS_W-1:0];
      if (c == CH_LF) begin
         done = 1'b1;
      end else begin
         if (!nul_hit) begin
            if (c == 8'h00) begin
               nul_hit = 1'b1;
            end else begin
               p = (prompt_idx >= PROMPT_LEN) ? 0 : prompt_idx;
               if (c == prompt_byte(p)) begin
                  p++;
                  if (p == PROMPT_LEN) begin
                     prompt_hit = 1'b1;
                     p = 0;
                  end
               end else begin
                  // first prompt char is unique, so restart at 0 or 1
                  p = (c == prompt_byte(0)) ? 1 : 0;
               end
               prompt_idx = p;
            end
         end
         // '>' at the end mark position is matched first, then closes the line
         if (line_pos == GT_END_POS && c == {1'b0, CH_GT})
            done = 1'b1;
      end
      if (done) begin
         beat.done  = 1'b1;
         beat.found = prompt_hit;
         line_pos   = 0;
         prompt_idx = 0;
         prompt_hit = 1'b0;
         nul_hit    = 1'b0;
      end else begin
         line_pos++;
      end
      return beat;
   endfunction

   // Line filler: mostly printable, some arbitrary bytes, some CRs, never LF.
   function automatic logic [RX_W-1:0] filler();
      int              r;
      logic [RX_W-1:0] b;
      r = $urandom_range(99);
      if (r < 75)
         return RX_W'($urandom_range(8'h20, 8'h7E));
      if (r < 90) begin
         b = RX_W'($urandom_range(255));
         return (b == CH_LF) ? 8'h0B : b;
      end
      return CH_CR;
   endfunction

   // Queues the first cut prompt chars, optionally sprinkled with CRs.
   task automatic queue_prompt(input int cut, input bit with_cr);
      for (int i = 0; i < cut; i++) begin
         if (with_cr && $urandom_range(4) == 0)
            pending_bytes.push_back(CH_CR);
         pending_bytes.push_back(prompt_byte(i));
      end
   endtask

   // Plans one stretch of traffic. Most of it is well-formed lines with the
   // prompt in various states; the rest is raw noise.
   task automatic plan_line();
      int kind;
      kind = $urandom_range(99);
      if (kind < 30) begin
         // full prompt somewhere in a line
         repeat ($urandom_range(20)) pending_bytes.push_back(filler());
         queue_prompt(PROMPT_LEN, $urandom_range(3) == 0);
         repeat ($urandom_range(4)) pending_bytes.push_back(filler());
         pending_bytes.push_back(CH_LF);
      end else if (kind < 45) begin
         // prompt broken off, then maybe restarted
         queue_prompt($urandom_range(1, PROMPT_LEN - 1), 1'b0);
         pending_bytes.push_back($urandom_range(1) ? prompt_byte(0) : filler());
         if ($urandom_range(1))
            queue_prompt(PROMPT_LEN, 1'b0);
         pending_bytes.push_back(CH_LF);
      end else if (kind < 55) begin
         // zero byte before or after the prompt
         repeat ($urandom_range(6)) pending_bytes.push_back(filler());
         if ($urandom_range(1)) begin
            pending_bytes.push_back(8'h00);
            queue_prompt(PROMPT_LEN, 1'b0);
         end else begin
            queue_prompt(PROMPT_LEN, 1'b0);
            pending_bytes.push_back(8'h00);
         end
         pending_bytes.push_back(CH_LF);
      end else if (kind < 63) begin
         // run past the line length so the position wraps
         repeat ($urandom_range(LINE_LEN_DEF - 12, 2 * LINE_LEN_DEF + 10))
            pending_bytes.push_back(filler());
         if ($urandom_range(1))
            queue_prompt(PROMPT_LEN, 1'b0);
         pending_bytes.push_back(CH_LF);
      end else if (kind < 73) begin
         // '>' landing on the end mark position
         repeat (GT_END_POS)
            pending_bytes.push_back(RX_W'($urandom_range(8'h20, 8'h7E)));
         pending_bytes.push_back({1'b0, CH_GT});
      end else begin
         repeat ($urandom_range(1, 30))
            pending_bytes.push_back(RX_W'($urandom_range(255)));
      end
   endtask

   // Sends one beat, with random idle cycles ahead of it, and queues the
   // expected response once the byte is accepted.
   task automatic send_byte(input logic [RX_W-1:0] rx, input bit typed,
                            input framer_beat_type want);
      framer_beat_type predicted;
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= rx;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predicted = frame_byte(rx);
      beats_due.push_back(typed ? want : predicted);
   endtask

   // Receiver: ready drops at random per the current stall rate.
   always @(posedge clock) begin
      rsp_ch.ready <= !reset && ($urandom_range(99) >= stall_pct);
   end

   // Response checker.
   always @(posedge clock) begin
      framer_beat_type got;
      framer_beat_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = {rsp_ch.char_kept, rsp_ch.char_out, rsp_ch.char_pos,
                rsp_ch.line_done, rsp_ch.prompt_found};
         if (beats_due.size() == 0) begin
            bad_beats++;
            if (bad_beats <= 10)
               $display("unexpected rsp beat: kept=%0d ch=%h pos=%0d done=%0d found=%0d",
                        got.kept, got.ch, got.pos, got.done, got.found);
         end else begin
            want = beats_due.pop_front();
            if (got !== want) begin
               bad_beats++;
               if (bad_beats <= 10) begin
                  $display("rsp mismatch: want kept=%0d ch=%h pos=%0d done=%0d found=%0d",
                           want.kept, want.ch, want.pos, want.done, want.found);
                  $display("              got  kept=%0d ch=%h pos=%0d done=%0d found=%0d",
                           got.kept, got.ch, got.pos, got.done, got.found);
               end
            end
         end
      end
   end

   // Watchdog: any handshake resets the count.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int idle_tab[4];
      int stall_tab[4];
      int sent;
      idle_tab  = '{0, 47, 0, 26};
      stall_tab = '{0, 0, 47, 26};
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.rx_byte = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Phases: no idling, sender idle, receiver stalling, both.
      for (int ph = 0; ph < 4; ph++) begin
         idle_pct  = idle_tab[ph];
         stall_pct = stall_tab[ph];
         if (ph == 0)
            foreach (dir_rows[i])
               send_byte(dir_rows[i].rx, dir_rows[i].typed, dir_rows[i].want);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            plan_line();
            while (pending_bytes.size() != 0) begin
               send_byte(pending_bytes.pop_front(), 1'b0, '0);
               sent++;
            end
         end
      end
      req_ch.valid <= 1'b0;

      // Drain; the watchdog covers a response that never shows up.
      while (beats_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (bad_beats == 0 && beats_due.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
src/slfpd_pkg.sv
src/slfpd_if.sv
src/serial_line_framer_prompt_detect.sv
tb/serial_line_framer_prompt_detect_test.sv
